/* hdl/fpem_pkg.sv */
// fpem_pkg: shared types, register/cause codes and thresholds for the
// flight phase and emergency monitor. No dependencies.
`default_nettype none

package fpem_pkg;

  localparam int AltW      = 20;
  localparam int VelW      = 15;
  localparam int TempW     = 12;
  localparam int ErrW      = 8;
  localparam int MemW      = 7;
  localparam int PhaseW    = 3;
  localparam int CauseW    = 3;
  localparam int PeakAltW  = 16;
  localparam int PeakVelW  = 14;
  localparam int StatTempW = 15;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 20;
  localparam int InDataW   = 64;
  localparam int OutDataW  = 72;

  // input sample, altitude in the lowest bits
  typedef struct packed {
    logic                    clear_request;
    logic [MemW-1:0]         memory_percent;
    logic [ErrW-1:0]         error_total;
    logic signed [TempW-1:0] temperature;
    logic signed [VelW-1:0]  velocity;
    logic signed [AltW-1:0]  altitude;
  } sample_t;

  // result, phase in the lowest bits
  typedef struct packed {
    logic signed [StatTempW-1:0] lowest_temperature;
    logic signed [StatTempW-1:0] peak_temperature;
    logic [PeakVelW-1:0]         peak_velocity;
    logic [PeakAltW-1:0]         peak_altitude_m;
    logic [CauseW-1:0]           emergency_cause;
    logic                        emergency_raised;
    logic                        emergency_active;
    logic                        phase_changed;
    logic [PhaseW-1:0]           phase;
  } result_t;

  localparam int SampleW = $bits(sample_t);
  localparam int ResultW = $bits(result_t);

  typedef struct packed {
    logic                    phase_detect_enable;
    logic signed [AltW-1:0]  alt_limit;
    logic signed [TempW-1:0] temp_limit;
    logic [PeakVelW-1:0]     speed_limit;
    logic [ErrW-1:0]         err_limit;
  } cfg_t;

  typedef enum logic [CfgIdxW-1:0] {
    RegPhaseEn    = 3'd0,
    RegAltLimit   = 3'd1,
    RegTempLimit  = 3'd2,
    RegSpeedLimit = 3'd3,
    RegErrLimit   = 3'd4
  } cfg_reg_e;

  typedef enum logic [CauseW-1:0] {
    CauseNone   = 3'd0,
    CauseAlt    = 3'd1,
    CauseTemp   = 3'd2,
    CauseSpeed  = 3'd3,
    CauseErrors = 3'd4,
    CauseMemory = 3'd5
  } cause_e;

  typedef enum logic [7:0] {
    PhGround   = 8'b0000_0001,
    PhLaunch   = 8'b0000_0010,
    PhPowered  = 8'b0000_0100,
    PhBalloon  = 8'b0000_1000,
    PhApex     = 8'b0001_0000,
    PhChute    = 8'b0010_0000,
    PhLanding  = 8'b0100_0000,
    PhRecovery = 8'b1000_0000
  } phase_e;

  // configuration reset values
  localparam logic                    PhaseEnRst    = 1'b1;
  localparam logic signed [AltW-1:0]  AltLimitRst   = 20'sd400000;
  localparam logic signed [TempW-1:0] TempLimitRst  = 12'sd850;
  localparam logic [PeakVelW-1:0]     SpeedLimitRst = 14'd3000;
  localparam logic [ErrW-1:0]         ErrLimitRst   = 8'd10;

  // phase thresholds, 0.1 units
  localparam logic signed [AltW-1:0] LaunchAlt   = 20'sd100;
  localparam logic signed [VelW-1:0] LaunchVel   = 15'sd50;
  localparam logic signed [AltW-1:0] PoweredAlt  = 20'sd1000;
  localparam logic signed [VelW-1:0] PoweredVel  = 15'sd100;
  localparam logic signed [AltW-1:0] BalloonAlt  = 20'sd10000;
  localparam logic signed [VelW-1:0] BalloonVel  = 15'sd10;
  localparam logic signed [VelW-1:0] ApexVel     = -15'sd20;
  localparam logic signed [VelW-1:0] ChuteVel    = -15'sd50;
  localparam logic signed [AltW-1:0] LandAlt     = 20'sd1000;
  localparam logic [VelW-1:0]        LandSpeed   = 15'd20;
  localparam logic signed [AltW-1:0] RecoveryAlt = 20'sd100;
  localparam logic [VelW-1:0]        RecSpeed    = 15'd5;

  localparam logic [MemW-1:0] MemLimit = 7'd95;

  localparam logic signed [StatTempW-1:0] TempMaxRst = -15'sd9990;
  localparam logic signed [StatTempW-1:0] TempMinRst = 15'sd9990;

  // x / 10 as (x * Div10Mul) >> Div10Shift, exact for 20-bit x
  localparam logic [AltW-1:0] Div10Mul   = 20'hCCCCD;
  localparam int              Div10Shift = 23;

  function automatic logic [VelW-1:0] abs_vel(logic signed [VelW-1:0] v);
    logic [VelW-1:0] r;
    r = v[VelW-1] ? VelW'(-v) : VelW'(v);
    return r;
  endfunction

  function automatic logic [PhaseW-1:0] phase_code(phase_e p);
    logic [PhaseW-1:0] c;
    case (p)
      PhGround:   c = 3'd0;
      PhLaunch:   c = 3'd1;
      PhPowered:  c = 3'd2;
      PhBalloon:  c = 3'd3;
      PhApex:     c = 3'd4;
      PhChute:    c = 3'd5;
      PhLanding:  c = 3'd6;
      PhRecovery: c = 3'd7;
      default:    c = 3'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* hdl/fpem_phase.sv */
// fpem_phase: one-hot flight phase sequencer, one step per sample.
// Depends on fpem_pkg.
`default_nettype none

module fpem_phase
  import fpem_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              upd_i,
  input  wire logic              enable_i,
  input  wire sample_t           sample_i,
  output logic [PhaseW-1:0]      phase_o,
  output logic                   changed_o
);

  phase_e phase_q, phase_d, next_ph;
  logic signed [AltW-1:0] a;
  logic signed [VelW-1:0] v;
  logic [VelW-1:0]        av;

  assign a  = sample_i.altitude;
  assign v  = sample_i.velocity;
  assign av = abs_vel(v);

  always_comb begin
    next_ph = phase_q;
    case (phase_q)
      PhGround:   if (v > LaunchVel && a > LaunchAlt) next_ph = PhLaunch;
      PhLaunch:   if (a > PoweredAlt && v > PoweredVel) next_ph = PhPowered;
      PhPowered:  if (v < BalloonVel && a > BalloonAlt) next_ph = PhBalloon;
      PhBalloon:  if (v < ApexVel) next_ph = PhApex;
      PhApex:     if (v < ChuteVel) next_ph = PhChute;
      PhChute:    if (a < LandAlt && av < LandSpeed) next_ph = PhLanding;
      PhLanding:  if (av < RecSpeed && a < RecoveryAlt) next_ph = PhRecovery;
      PhRecovery: next_ph = PhRecovery;
      default:    next_ph = phase_q;
    endcase
  end

  assign changed_o = enable_i && (next_ph != phase_q);
  assign phase_d   = changed_o ? next_ph : phase_q;
  assign phase_o   = phase_code(phase_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhGround;
    end else if (upd_i) begin
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/fpem_emerg.sv */
// fpem_emerg: emergency latch with ordered threshold checks and cause.
// Depends on fpem_pkg.
`default_nettype none

module fpem_emerg
  import fpem_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         upd_i,
  input  wire cfg_t         cfg_i,
  input  wire sample_t      sample_i,
  output logic              active_o,
  output logic              raised_o,
  output logic [CauseW-1:0] cause_o
);

  logic   latch_q, latch_d, latch_eff;
  cause_e cause_q, cause_d, cause_eff, cause_new;
  logic [VelW-1:0] av;

  assign av = abs_vel(sample_i.velocity);

  always_comb begin
    if (sample_i.altitude > cfg_i.alt_limit) begin
      cause_new = CauseAlt;
    end else if (sample_i.temperature > cfg_i.temp_limit) begin
      cause_new = CauseTemp;
    end else if (av > {1'b0, cfg_i.speed_limit}) begin
      cause_new = CauseSpeed;
    end else if (sample_i.error_total > cfg_i.err_limit) begin
      cause_new = CauseErrors;
    end else if (sample_i.memory_percent > MemLimit) begin
      cause_new = CauseMemory;
    end else begin
      cause_new = CauseNone;
    end
  end

  // clear takes effect before the checks
  assign latch_eff = sample_i.clear_request ? 1'b0 : latch_q;
  assign cause_eff = sample_i.clear_request ? CauseNone : cause_q;
  assign raised_o  = !latch_eff && (cause_new != CauseNone);
  assign latch_d   = latch_eff || raised_o;
  assign cause_d   = raised_o ? cause_new : cause_eff;
  assign active_o  = latch_d;
  assign cause_o   = cause_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q <= 1'b0;
      cause_q <= CauseNone;
    end else if (upd_i) begin
      latch_q <= latch_d;
      cause_q <= cause_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/fpem_stats.sv */
// fpem_stats: peak altitude (whole meters), peak velocity, temperature extremes.
// Depends on fpem_pkg.
`default_nettype none

module fpem_stats
  import fpem_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  upd_i,
  input  wire sample_t               sample_i,
  output logic [PeakAltW-1:0]        peak_alt_o,
  output logic [PeakVelW-1:0]        peak_vel_o,
  output logic signed [StatTempW-1:0] max_temp_o,
  output logic signed [StatTempW-1:0] min_temp_o
);

  logic [PeakAltW-1:0]         alt_q, alt_d;
  logic [PeakVelW-1:0]         vel_q, vel_d;
  logic signed [StatTempW-1:0] tmax_q, tmax_d, tmin_q, tmin_d;
  logic [AltW-1:0]             alt_x10;
  logic [2*AltW-1:0]           div_prod;
  logic signed [StatTempW-1:0] t_ext;

  // stored meters times ten, fits 20 bits unsigned
  assign alt_x10  = {1'b0, alt_q, 3'b000} + {3'b000, alt_q, 1'b0};
  assign div_prod = {{AltW{1'b0}}, sample_i.altitude} * {{AltW{1'b0}}, Div10Mul};
  assign t_ext    = StatTempW'(sample_i.temperature);

  always_comb begin
    alt_d = alt_q;
    if ($signed({sample_i.altitude[AltW-1], sample_i.altitude}) > $signed({1'b0, alt_x10})) begin
      alt_d = div_prod[Div10Shift +: PeakAltW];
    end
    vel_d = vel_q;
    if (sample_i.velocity > $signed({1'b0, vel_q})) begin
      vel_d = sample_i.velocity[PeakVelW-1:0];
    end
    tmax_d = (t_ext > tmax_q) ? t_ext : tmax_q;
    tmin_d = (t_ext < tmin_q) ? t_ext : tmin_q;
  end

  assign peak_alt_o = alt_d;
  assign peak_vel_o = vel_d;
  assign max_temp_o = tmax_d;
  assign min_temp_o = tmin_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alt_q  <= '0;
      vel_q  <= '0;
      tmax_q <= TempMaxRst;
      tmin_q <= TempMinRst;
    end else if (upd_i) begin
      alt_q  <= alt_d;
      vel_q  <= vel_d;
      tmax_q <= tmax_d;
      tmin_q <= tmin_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/flight_phase_and_emergency_monitor.sv */
// Flight phase and emergency monitor, top level. An accepted request goes to
// the input register, then its result to the result register. Throughput:
// one request per cycle unless the output stalls; the result register is set
// by the phase, emergency and statistics logic in a single pass.
// Reset (async, active low) clears phase, latch, peaks and restores config.
// Depends on fpem_pkg, fpem_phase, fpem_emerg, fpem_stats.
`default_nettype none

module flight_phase_and_emergency_monitor
  import fpem_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // altitude, velocity, temperature, error_total, memory_percent, clear_request
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // phase, phase_changed, emergency_active, emergency_raised, emergency_cause,
  // peak_altitude_m, peak_velocity, peak_temperature, lowest_temperature
  output logic [OutDataW-1:0]      m_axis_tdata_o
);

  cfg_t    cfg_q;
  logic    in_valid_q, out_valid_q, adv, in_acc;
  sample_t in_q;
  result_t res_d, res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_detect_enable <= PhaseEnRst;
      cfg_q.alt_limit           <= AltLimitRst;
      cfg_q.temp_limit          <= TempLimitRst;
      cfg_q.speed_limit         <= SpeedLimitRst;
      cfg_q.err_limit           <= ErrLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegPhaseEn:    cfg_q.phase_detect_enable <= cfg_wdata_i[0];
        RegAltLimit:   cfg_q.alt_limit           <= cfg_wdata_i[AltW-1:0];
        RegTempLimit:  cfg_q.temp_limit          <= cfg_wdata_i[TempW-1:0];
        RegSpeedLimit: cfg_q.speed_limit         <= cfg_wdata_i[PeakVelW-1:0];
        RegErrLimit:   cfg_q.err_limit           <= cfg_wdata_i[ErrW-1:0];
        default: ;
      endcase
    end
  end

  assign adv             = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= sample_t'(s_axis_tdata_i[SampleW-1:0]);
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  fpem_phase u_phase (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .upd_i     (adv),
    .enable_i  (cfg_q.phase_detect_enable),
    .sample_i  (in_q),
    .phase_o   (res_d.phase),
    .changed_o (res_d.phase_changed)
  );

  fpem_emerg u_emerg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (adv),
    .cfg_i    (cfg_q),
    .sample_i (in_q),
    .active_o (res_d.emergency_active),
    .raised_o (res_d.emergency_raised),
    .cause_o  (res_d.emergency_cause)
  );

  fpem_stats u_stats (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (adv),
    .sample_i   (in_q),
    .peak_alt_o (res_d.peak_altitude_m),
    .peak_vel_o (res_d.peak_velocity),
    .max_temp_o (res_d.peak_temperature),
    .min_temp_o (res_d.lowest_temperature)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW-ResultW){1'b0}}, res_q};

endmodule

`default_nettype wire
